/* rtl/core/psb_pkg.sv */
package psb_pkg;

  localparam int unsigned WORD_W       = 32;
  localparam int unsigned HEADER_WORDS = 6;

  // record tags; quads leave the block as triangles
  localparam logic [1:0] TAG_POINT = 2'd0;
  localparam logic [1:0] TAG_LINE  = 2'd1;
  localparam logic [1:0] TAG_TRI   = 2'd2;
  localparam logic [1:0] TAG_QUAD  = 2'd3;

  typedef struct packed {
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
  } vertex_t;

  // controller to datapath
  typedef struct packed {
    logic       rec_wr;
    logic [3:0] rec_idx;
    logic       append;
    logic [1:0] vsel;
    logic       flush_start;
    logic [1:0] flush_kind;
    logic       clear_count;
  } psb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       count_zero;
    logic       flush_busy;
    logic [3:0] no_room;
  } psb_sts_t;

  // coordinate words in a record of the given tag
  function automatic logic [3:0] rec_words(input logic [1:0] tag);
    rec_words = 4'({2'b00, tag} + 4'd1) * 4'd3;
  endfunction

  // vertices appended to the batch for one record
  function automatic logic [2:0] rec_appends(input logic [1:0] tag);
    if (tag == TAG_QUAD) begin
      rec_appends = 3'd6;
    end else begin
      rec_appends = {1'b0, tag} + 3'd1;
    end
  endfunction

  // quad split into (0,1,2) and (0,2,3)
  function automatic logic [1:0] quad_vsel(input logic [2:0] step);
    case (step)
      3'd0:    quad_vsel = 2'd0;
      3'd1:    quad_vsel = 2'd1;
      3'd2:    quad_vsel = 2'd2;
      3'd3:    quad_vsel = 2'd0;
      3'd4:    quad_vsel = 2'd2;
      3'd5:    quad_vsel = 2'd3;
      default: quad_vsel = 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] kind_of_tag(input logic [1:0] tag);
    kind_of_tag = (tag == TAG_QUAD) ? TAG_TRI : tag;
  endfunction

endpackage

/* rtl/core/psb_stream_if.sv */
interface psb_in_if;
  import psb_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] stream_word;
  logic              end_of_stream;

  modport source (output valid, output stream_word, output end_of_stream, input ready);
  modport sink   (input valid, input stream_word, input end_of_stream, output ready);
endinterface

interface psb_out_if;
  import psb_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        prim_kind;
  logic [WORD_W-1:0] vert_x;
  logic [WORD_W-1:0] vert_y;
  logic [WORD_W-1:0] vert_z;
  logic              batch_last;

  modport source (output valid, output prim_kind, output vert_x, output vert_y,
                  output vert_z, output batch_last, input ready);
  modport sink   (input valid, input prim_kind, input vert_x, input vert_y,
                  input vert_z, input batch_last, output ready);
endinterface

/* rtl/core/psb_datapath.sv */
module psb_datapath import psb_pkg::*; #(
  parameter int unsigned BATCH_VERTICES = 48
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [WORD_W-1:0] word_i,
  input  psb_cmd_t          cmd_i,
  output psb_sts_t          sts_o,
  psb_out_if.source         out_o
);

  localparam int unsigned CW = $clog2(BATCH_VERTICES + 1);
  localparam int unsigned AW = $clog2(BATCH_VERTICES);

  logic [WORD_W-1:0] rec_q [4][3];
  vertex_t           mem_q [BATCH_VERTICES];

  logic [CW-1:0] count_q;
  logic [AW-1:0] rd_idx_q;
  logic          busy_q;
  logic [1:0]    fkind_q;
  logic          out_valid_q;
  vertex_t       rd_vert_q;
  logic [1:0]    out_kind_q;
  logic          out_last_q;

  logic          out_fire;
  logic          issue;
  logic          is_last;
  logic          app_en;
  logic [1:0]    wr_vi;
  logic [1:0]    wr_ci;
  vertex_t       app_vert;
  logic [CW:0]   room_sum [4];

  function automatic logic [3:0] split_idx(input logic [3:0] idx);
    case (idx)
      4'd0:    split_idx = {2'd0, 2'd0};
      4'd1:    split_idx = {2'd0, 2'd1};
      4'd2:    split_idx = {2'd0, 2'd2};
      4'd3:    split_idx = {2'd1, 2'd0};
      4'd4:    split_idx = {2'd1, 2'd1};
      4'd5:    split_idx = {2'd1, 2'd2};
      4'd6:    split_idx = {2'd2, 2'd0};
      4'd7:    split_idx = {2'd2, 2'd1};
      4'd8:    split_idx = {2'd2, 2'd2};
      4'd9:    split_idx = {2'd3, 2'd0};
      4'd10:   split_idx = {2'd3, 2'd1};
      4'd11:   split_idx = {2'd3, 2'd2};
      default: split_idx = {2'd3, 2'd2};
    endcase
  endfunction

  assign {wr_vi, wr_ci} = split_idx(cmd_i.rec_idx);

  assign out_fire = out_valid_q && out_o.ready;
  assign issue    = busy_q && (!out_valid_q || out_fire);
  assign is_last  = (CW'(rd_idx_q) + CW'(1)) == count_q;
  assign app_en   = cmd_i.append && (count_q < CW'(BATCH_VERTICES));

  assign app_vert.x = rec_q[cmd_i.vsel][0];
  assign app_vert.y = rec_q[cmd_i.vsel][1];
  assign app_vert.z = rec_q[cmd_i.vsel][2];

  // record buffer
  always_ff @(posedge clk_i) begin
    if (cmd_i.rec_wr) begin
      rec_q[wr_vi][wr_ci] <= word_i;
    end
  end

  // batch memory, read port doubles as the output payload register
  always_ff @(posedge clk_i) begin
    if (app_en) begin
      mem_q[count_q[AW-1:0]] <= app_vert;
    end
    if (issue) begin
      rd_vert_q  <= mem_q[rd_idx_q];
      out_kind_q <= fkind_q;
      out_last_q <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rd_idx_q    <= '0;
      busy_q      <= 1'b0;
      fkind_q     <= TAG_POINT;
      out_valid_q <= 1'b0;
    end else begin
      // the batch empties on a clear or once its last vertex is issued
      if (cmd_i.clear_count || (issue && is_last && !cmd_i.flush_start)) begin
        count_q <= '0;
      end else if (app_en) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.flush_start) begin
        busy_q   <= 1'b1;
        rd_idx_q <= '0;
        fkind_q  <= cmd_i.flush_kind;
      end else if (issue) begin
        rd_idx_q <= rd_idx_q + AW'(1);
        if (is_last) begin
          busy_q <= 1'b0;
        end
      end
      if (issue) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.count_zero = (count_q == '0);
    sts_o.flush_busy = busy_q;
    for (int k = 0; k < 4; k++) begin
      room_sum[k]      = {1'b0, count_q} + (CW+1)'(rec_appends(2'(k)));
      sts_o.no_room[k] = room_sum[k] > (CW+1)'(BATCH_VERTICES);
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.prim_kind  = out_kind_q;
  assign out_o.vert_x     = rd_vert_q.x;
  assign out_o.vert_y     = rd_vert_q.y;
  assign out_o.vert_z     = rd_vert_q.z;
  assign out_o.batch_last = out_last_q;

endmodule

/* rtl/core/psb_ctrl.sv */
module psb_ctrl import psb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [WORD_W-1:0] in_word_i,
  input  logic              in_eos_i,
  output logic              in_ready_o,
  input  psb_sts_t          sts_i,
  output psb_cmd_t          cmd_o
);

  localparam logic [2:0] S_HEADER = 3'd0;
  localparam logic [2:0] S_TAG    = 3'd1;
  localparam logic [2:0] S_VERTS  = 3'd2;
  localparam logic [2:0] S_HALT   = 3'd3;
  localparam logic [2:0] S_APPEND = 3'd4;
  localparam logic [2:0] S_DECIDE = 3'd5;
  localparam logic [2:0] S_FLUSH  = 3'd6;

  logic [2:0] state_q, state_d;
  logic [2:0] ret_q, ret_d;
  logic [2:0] hdr_q, hdr_d;
  logic [3:0] wir_q, wir_d;
  logic [1:0] kind_q, kind_d;
  logic [1:0] tag_q, tag_d;
  logic       tag_vld_q, tag_vld_d;
  logic [2:0] step_q, step_d;

  logic       fire;
  logic       change;
  logic       bad_tag;
  logic [2:0] after_tag;

  assign in_ready_o = (state_q == S_HEADER) || (state_q == S_TAG) ||
                      (state_q == S_VERTS)  || (state_q == S_HALT);
  assign fire      = in_valid_i && in_ready_o;
  assign change    = tag_vld_q && (in_word_i != {{(WORD_W-2){1'b0}}, tag_q});
  assign bad_tag   = |in_word_i[WORD_W-1:2];
  assign after_tag = bad_tag ? S_HALT : S_VERTS;

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    hdr_d     = hdr_q;
    wir_d     = wir_q;
    kind_d    = kind_q;
    tag_d     = tag_q;
    tag_vld_d = tag_vld_q;
    step_d    = step_q;
    cmd_o     = '0;

    if (fire && in_eos_i) begin
      if ((state_q == S_TAG) && tag_vld_q && !sts_i.count_zero) begin
        cmd_o.flush_start = 1'b1;
        cmd_o.flush_kind  = kind_of_tag(tag_q);
        ret_d             = S_HEADER;
        state_d           = S_FLUSH;
      end else begin
        cmd_o.clear_count = 1'b1;
        state_d           = S_HEADER;
      end
      hdr_d     = '0;
      wir_d     = '0;
      kind_d    = TAG_POINT;
      tag_d     = TAG_POINT;
      tag_vld_d = 1'b0;
    end else begin
      case (state_q)
        S_HEADER: begin
          if (fire) begin
            if (hdr_q == 3'(HEADER_WORDS - 1)) begin
              hdr_d   = '0;
              state_d = S_TAG;
            end else begin
              hdr_d = hdr_q + 3'd1;
            end
          end
        end
        S_TAG: begin
          if (fire) begin
            if (change) begin
              tag_vld_d = 1'b0;
            end
            if (!bad_tag) begin
              tag_d     = in_word_i[1:0];
              tag_vld_d = 1'b1;
              kind_d    = in_word_i[1:0];
              wir_d     = '0;
            end
            if (change && !sts_i.count_zero) begin
              cmd_o.flush_start = 1'b1;
              cmd_o.flush_kind  = kind_of_tag(tag_q);
              ret_d             = after_tag;
              state_d           = S_FLUSH;
            end else begin
              state_d = after_tag;
            end
          end
        end
        S_VERTS: begin
          if (fire) begin
            cmd_o.rec_wr  = 1'b1;
            cmd_o.rec_idx = wir_q;
            if (wir_q == rec_words(kind_q) - 4'd1) begin
              wir_d   = '0;
              step_d  = '0;
              state_d = S_APPEND;
            end else begin
              wir_d = wir_q + 4'd1;
            end
          end
        end
        S_APPEND: begin
          cmd_o.append = 1'b1;
          cmd_o.vsel   = (kind_q == TAG_QUAD) ? quad_vsel(step_q) : step_q[1:0];
          if (step_q == rec_appends(kind_q) - 3'd1) begin
            state_d = S_DECIDE;
          end else begin
            step_d = step_q + 3'd1;
          end
        end
        S_DECIDE: begin
          if (sts_i.no_room[kind_q]) begin
            cmd_o.flush_start = 1'b1;
            cmd_o.flush_kind  = kind_of_tag(tag_q);
            ret_d             = S_TAG;
            state_d           = S_FLUSH;
          end else begin
            state_d = S_TAG;
          end
        end
        S_FLUSH: begin
          if (!sts_i.flush_busy) begin
            state_d = ret_q;
          end
        end
        S_HALT: begin
          state_d = S_HALT;
        end
        default: begin
          state_d = S_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_HEADER;
      ret_q     <= S_HEADER;
      hdr_q     <= '0;
      wir_q     <= '0;
      kind_q    <= TAG_POINT;
      tag_q     <= TAG_POINT;
      tag_vld_q <= 1'b0;
      step_q    <= '0;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      hdr_q     <= hdr_d;
      wir_q     <= wir_d;
      kind_q    <= kind_d;
      tag_q     <= tag_d;
      tag_vld_q <= tag_vld_d;
      step_q    <= step_d;
    end
  end

endmodule

/* rtl/core/primitive_stream_batcher_unit.sv */
// primitive stream batcher
// in_i takes one dump word a beat (stream_word, or end_of_stream to close the
// dump); out_o gives one vertex a beat with its kind and a batch_last flag.
// parsing words (header, tag, coordinates) are taken one a cycle.
// after the last coordinate word of a record the unit appends the record's
// vertices (1 to 6, a quad gives 6) and then runs the full check; a record of
// k vertices is 3k+1 input words (its tag word and 3k coordinate words).
// a flush streams the batch out of the vertex memory one vertex per cycle,
// its length set by the vertices pending in the batch, then hands back
// to the parser; no words are taken while appending or flushing.
// the memory read register is the output register: a flush start (the beat of
// the triggering word, or the full check) sets the busy flag, and the first
// read then loads the first vertex into that register, which drives out_o.
// reset empties the batch and restarts the parser at the bounds header; the
// vertex memory and record buffer are not cleared (never read before written).
// a stalled out_o holds its beat and pauses the flush until ready returns.
module primitive_stream_batcher_unit import psb_pkg::*; #(
  parameter int unsigned BATCH_VERTICES = 48
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  psb_in_if.sink    in_i,
  psb_out_if.source out_o
);

  psb_cmd_t cmd;   // controller commands
  psb_sts_t sts;   // batch status back to the controller

  // parser and sequencer
  psb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_word_i  (in_i.stream_word),
    .in_eos_i   (in_i.end_of_stream),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // record buffer, vertex memory and output beat register
  psb_datapath #(
    .BATCH_VERTICES (BATCH_VERTICES)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .word_i (in_i.stream_word),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .out_o  (out_o)
  );

  // a flush is only started with vertices pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.flush_start |-> !sts.count_zero)
    else $error("flush started on an empty batch");

  // appending never overlaps a running flush
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.append |-> !sts.flush_busy)
    else $error("append during flush");

  // no input beat is taken while a flush is running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.flush_busy |-> !in_i.ready)
    else $error("input accepted during flush");

  // quads leave the unit as triangles
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.prim_kind != TAG_QUAD))
    else $error("quad kind on output");

endmodule
